// ----- rtl/prt_pkg.sv -----
// ----------------------------------------------------------------------------
// prt_pkg
// Types, codes and sizes shared by the prefix route table and its cells.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W       = IDX_W + 6;
    localparam int HIT_W       = 5;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_RSVD   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MISS      = 2'd1,
        ST_PROTECTED = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IFACE0_ADDR = 2'd0,
        REG_IFACE0_MASK = 2'd1,
        REG_IFACE1_ADDR = 2'd2,
        REG_IFACE1_MASK = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT
    } cell_op_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] mask;
        logic [31:0] net;
        logic [31:0] hop;
    } entry_t;

    typedef struct packed {
        logic below;
        logic match;
    } cell_flags_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] route_mask;
        logic [31:0] route_net;
        logic [31:0] route_next_hop;
        logic [4:0]  entry_index;
        logic [31:0] lookup_address;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [31:0]      next_hop;
        logic [HIT_W-1:0] hit_index;
    } out_item_t;

endpackage

// ----- rtl/prt_cell.sv -----
// ----------------------------------------------------------------------------
// prt_cell
// One user route slot. Holds an entry, compares it against the current key
// and takes a new entry, its neighbor's entry or keeps its own.
// ----------------------------------------------------------------------------
module prt_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  prt_pkg::cell_op_t    op,
    input  prt_pkg::entry_t      new_entry,
    input  prt_pkg::entry_t      prev_entry,
    input  prt_pkg::entry_t      next_entry,
    input  logic [31:0]          key_mask,
    input  logic [31:0]          key_addr,
    output prt_pkg::entry_t      entry,
    output prt_pkg::cell_flags_t flags
);

    logic            valid_reg;
    prt_pkg::entry_t data_reg;
    prt_pkg::entry_t entry_next;

    always_comb begin
        unique case (op)
            prt_pkg::CELL_LOAD:      entry_next = new_entry;
            prt_pkg::CELL_FROM_PREV: entry_next = prev_entry;
            prt_pkg::CELL_FROM_NEXT: entry_next = next_entry;
            default:                 entry_next = entry;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= entry_next.valid;
        end
        data_reg <= entry_next;
    end

    always_comb begin
        entry       = data_reg;
        entry.valid = valid_reg;
    end

    assign flags.below = !valid_reg || (data_reg.mask <= key_mask);
    assign flags.match = valid_reg && ((data_reg.mask & key_addr) == data_reg.net);

endmodule

// ----- rtl/prt_prio_enc.sv -----
// ----------------------------------------------------------------------------
// prt_prio_enc
// Finds the lowest set request bit across the cell row.
// ----------------------------------------------------------------------------
module prt_prio_enc (
    input  logic [prt_pkg::TABLE_DEPTH-1:0] req,
    output logic                            found,
    output logic [prt_pkg::IDX_W-1:0]       index
);

    always_comb begin
        index = '0;
        for (int i = prt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (req[i]) begin
                index = prt_pkg::IDX_W'(i);
            end
        end
    end

    assign found = |req;

endmodule

// ----- rtl/prefix_route_table.sv -----
// ----------------------------------------------------------------------------
// prefix_route_table
// IPv4 route table: two direct routes from the interface registers followed
// by a row of user route cells kept in descending mask order.
//
//   channel   ports                         direction
//   input     s_valid s_ready s_data        commands in
//   result    m_valid m_ready m_data        one result per command
//   config    cfg_valid cfg_ready cfg_index cfg_data   register writes
//
// The cell row compares, shifts and inserts in the accept cycle, and the
// result is registered for the next cycle.
// A new item is taken whenever the result register is empty or being read.
// Reset clears the cell valid bits, the fill count, the interface registers and the result valid bit.
// ----------------------------------------------------------------------------
module prefix_route_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  prt_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output prt_pkg::out_item_t              m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [prt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int D = prt_pkg::TABLE_DEPTH;

    logic [31:0] iface0_addr_reg, iface0_mask_reg, iface1_addr_reg, iface1_mask_reg;
    logic [prt_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      m_valid_reg;
    prt_pkg::out_item_t        m_data_reg, result;

    prt_pkg::entry_t      entries [D];
    prt_pkg::entry_t      prevs   [D];
    prt_pkg::entry_t      nexts   [D];
    prt_pkg::cell_op_t    ops     [D];
    prt_pkg::cell_flags_t flags   [D];
    prt_pkg::entry_t      new_entry;

    logic [D-1:0] below, match, first_below;
    logic                      pos_found, hit_found;
    logic [prt_pkg::IDX_W-1:0] pos_idx, hit_idx;

    logic accept, full, rm_ok, direct1, direct0;
    logic [prt_pkg::CMP_W-1:0] eidx_w, count_w;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign new_entry = '{valid: 1'b1, mask: s_data.route_mask,
                         net: s_data.route_net, hop: s_data.route_next_hop};

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign prevs[g]       = '0;
                assign first_below[g] = below[g];
            end else begin : g_rest
                assign prevs[g]       = entries[g-1];
                assign first_below[g] = below[g] && !below[g-1];
            end
            if (g == D - 1) begin : g_last
                assign nexts[g] = '0;
            end else begin : g_mid
                assign nexts[g] = entries[g+1];
            end

            prt_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .op         (ops[g]),
                .new_entry  (new_entry),
                .prev_entry (prevs[g]),
                .next_entry (nexts[g]),
                .key_mask   (s_data.route_mask),
                .key_addr   (s_data.lookup_address),
                .entry      (entries[g]),
                .flags      (flags[g])
            );

            assign below[g] = flags[g].below;
            assign match[g] = flags[g].match;
        end
    endgenerate

    prt_prio_enc u_pos_enc (.req(first_below), .found(pos_found), .index(pos_idx));
    prt_prio_enc u_hit_enc (.req(match),       .found(hit_found), .index(hit_idx));

    assign full    = (count_reg == prt_pkg::CNT_W'(D));
    assign eidx_w  = prt_pkg::CMP_W'(s_data.entry_index);
    assign count_w = prt_pkg::CMP_W'(count_reg);
    assign rm_ok   = (eidx_w >= prt_pkg::CMP_W'(2)) && (eidx_w < count_w + prt_pkg::CMP_W'(2));
    assign direct1 = (iface1_mask_reg & s_data.lookup_address)
                     == (iface1_addr_reg & iface1_mask_reg);
    assign direct0 = (iface0_mask_reg & s_data.lookup_address)
                     == (iface0_addr_reg & iface0_mask_reg);

    always_comb begin
        for (int i = 0; i < D; i++) begin
            ops[i] = prt_pkg::CELL_HOLD;
            if (accept) begin
                unique case (s_data.command)
                    prt_pkg::CMD_INSERT: begin
                        if (!full) begin
                            if (first_below[i]) begin
                                ops[i] = prt_pkg::CELL_LOAD;
                            end else if (below[i]) begin
                                ops[i] = prt_pkg::CELL_FROM_PREV;
                            end
                        end
                    end
                    prt_pkg::CMD_REMOVE: begin
                        if (rm_ok && (prt_pkg::CMP_W'(i) + prt_pkg::CMP_W'(2) >= eidx_w)) begin
                            ops[i] = prt_pkg::CELL_FROM_NEXT;
                        end
                    end
                    default: ops[i] = prt_pkg::CELL_HOLD;
                endcase
            end
        end
    end

    always_comb begin
        result     = '{status: prt_pkg::ST_MISS, next_hop: '0, hit_index: '0};
        count_next = count_reg;
        unique case (s_data.command)
            prt_pkg::CMD_INSERT: begin
                if (full || !pos_found) begin
                    result.status = prt_pkg::ST_FULL;
                end else begin
                    result.status    = prt_pkg::ST_OK;
                    result.hit_index = prt_pkg::HIT_W'(prt_pkg::CMP_W'(pos_idx)
                                                       + prt_pkg::CMP_W'(2));
                    count_next       = count_reg + prt_pkg::CNT_W'(1);
                end
            end
            prt_pkg::CMD_REMOVE: begin
                result.hit_index = s_data.entry_index;
                if (eidx_w < prt_pkg::CMP_W'(2)) begin
                    result.status = prt_pkg::ST_PROTECTED;
                end else if (rm_ok) begin
                    result.status = prt_pkg::ST_OK;
                    count_next    = count_reg - prt_pkg::CNT_W'(1);
                end
            end
            prt_pkg::CMD_LOOKUP: begin
                if (direct1) begin
                    result.status = prt_pkg::ST_OK;
                end else if (direct0) begin
                    result.status    = prt_pkg::ST_OK;
                    result.hit_index = prt_pkg::HIT_W'(1);
                end else if (hit_found) begin
                    result.status    = prt_pkg::ST_OK;
                    result.next_hop  = entries[hit_idx].hop;
                    result.hit_index = prt_pkg::HIT_W'(prt_pkg::CMP_W'(hit_idx)
                                                       + prt_pkg::CMP_W'(2));
                end
            end
            default: result.status = prt_pkg::ST_MISS;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iface0_addr_reg <= '0;
            iface0_mask_reg <= '0;
            iface1_addr_reg <= '0;
            iface1_mask_reg <= '0;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (prt_pkg::reg_idx_t'(cfg_index))
                    prt_pkg::REG_IFACE0_ADDR: iface0_addr_reg <= cfg_data;
                    prt_pkg::REG_IFACE0_MASK: iface0_mask_reg <= cfg_data;
                    prt_pkg::REG_IFACE1_ADDR: iface1_addr_reg <= cfg_data;
                    default:                  iface1_mask_reg <= cfg_data;
                endcase
            end
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_data_reg <= result;
        end
    end

endmodule

// ----- rtl/prt_checker.sv -----
// ----------------------------------------------------------------------------
// prt_checker
// Port-level checks for the prefix route table, bound to the top level.
// ----------------------------------------------------------------------------
module prt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input prt_pkg::out_item_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result item changed while stalled.");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("Input stalled with an empty result register.");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("Accepted item gave no result.");

    a_hop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != prt_pkg::ST_OK) |-> (m_data.next_hop == 32'd0))
        else $error("Failed command carries a next hop.");

    a_protected: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == prt_pkg::ST_PROTECTED)
            |-> (m_data.hit_index < prt_pkg::HIT_W'(2)))
        else $error("Protected status on a user route position.");

endmodule

bind prefix_route_table prt_checker u_prt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/prefix_route_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_route_table_tb
// Drives inserts, removes, lookups and reserved commands into the route table
// under several interface settings and handshake idling patterns. A
// scoreboard keeps its own copy of the table, predicts every reply and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module prefix_route_table_tb;

    class route_scoreboard;
        bit [31:0] if0_addr, if0_mask, if1_addr, if1_mask;
        bit [31:0] masks[prt_pkg::TABLE_DEPTH];
        bit [31:0] nets[prt_pkg::TABLE_DEPTH];
        bit [31:0] hops[prt_pkg::TABLE_DEPTH];
        int route_count;
        prt_pkg::out_item_t expected_replies[$];
        bit failed;

        function void write_reg(prt_pkg::reg_idx_t idx, bit [31:0] value);
            case (idx)
                prt_pkg::REG_IFACE0_ADDR: if0_addr = value;
                prt_pkg::REG_IFACE0_MASK: if0_mask = value;
                prt_pkg::REG_IFACE1_ADDR: if1_addr = value;
                prt_pkg::REG_IFACE1_MASK: if1_mask = value;
            endcase
        endfunction

        function prt_pkg::out_item_t reply(prt_pkg::status_t st, bit [31:0] hop, int idx);
            prt_pkg::out_item_t r;
            r.status = st;
            r.next_hop = hop;
            r.hit_index = idx[prt_pkg::HIT_W-1:0];
            return r;
        endfunction

        function void take_command(prt_pkg::in_item_t c);
            prt_pkg::out_item_t r;
            int pos;
            int e;
            e = c.entry_index;
            r = reply(prt_pkg::ST_MISS, 0, 0);
            case (c.command)
                prt_pkg::CMD_INSERT: begin
                    if (route_count >= prt_pkg::TABLE_DEPTH) begin
                        r = reply(prt_pkg::ST_FULL, 0, 0);
                    end else begin
                        pos = route_count;
                        for (int i = route_count - 1; i >= 0; i--) begin
                            if (masks[i] <= c.route_mask) pos = i;
                        end
                        for (int i = route_count; i > pos; i--) begin
                            masks[i] = masks[i-1];
                            nets[i] = nets[i-1];
                            hops[i] = hops[i-1];
                        end
                        masks[pos] = c.route_mask;
                        nets[pos] = c.route_net;
                        hops[pos] = c.route_next_hop;
                        route_count++;
                        r = reply(prt_pkg::ST_OK, 0, pos + 2);
                    end
                end
                prt_pkg::CMD_REMOVE: begin
                    if (e < 2) begin
                        r = reply(prt_pkg::ST_PROTECTED, 0, e);
                    end else if (e - 2 >= route_count) begin
                        r = reply(prt_pkg::ST_MISS, 0, e);
                    end else begin
                        for (int i = e - 2; i + 1 < route_count; i++) begin
                            masks[i] = masks[i+1];
                            nets[i] = nets[i+1];
                            hops[i] = hops[i+1];
                        end
                        route_count--;
                        r = reply(prt_pkg::ST_OK, 0, e);
                    end
                end
                prt_pkg::CMD_LOOKUP: begin
                    if ((if1_mask & c.lookup_address) == (if1_addr & if1_mask)) begin
                        r = reply(prt_pkg::ST_OK, 0, 0);
                    end else if ((if0_mask & c.lookup_address) == (if0_addr & if0_mask)) begin
                        r = reply(prt_pkg::ST_OK, 0, 1);
                    end else begin
                        for (int i = route_count - 1; i >= 0; i--) begin
                            if ((masks[i] & c.lookup_address) == nets[i])
                                r = reply(prt_pkg::ST_OK, hops[i], i + 2);
                        end
                    end
                end
                default: r = reply(prt_pkg::ST_MISS, 0, 0);
            endcase
            expected_replies.push_back(r);
        endfunction

        function void check_reply(prt_pkg::out_item_t got);
            prt_pkg::out_item_t want;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected item status=%0d next_hop=%h hit_index=%0d",
                         $time, got.status, got.next_hop, got.hit_index);
                failed = 1;
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                failed = 1;
            end
            if (got.next_hop !== want.next_hop) begin
                $display("%0t: next_hop expected %h actual %h",
                         $time, want.next_hop, got.next_hop);
                failed = 1;
            end
            if (got.hit_index !== want.hit_index) begin
                $display("%0t: hit_index expected %0d actual %0d",
                         $time, want.hit_index, got.hit_index);
                failed = 1;
            end
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    prt_pkg::in_item_t             s_data = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    prt_pkg::out_item_t            m_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [prt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit pressure_on = 0;
    bit hold_off = 0;
    route_scoreboard routes = new();

    prefix_route_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        wait (pressure_on);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                routes.write_reg(prt_pkg::reg_idx_t'(cfg_index), cfg_data);
            if (s_valid && s_ready) routes.take_command(s_data);
            if (m_valid && m_ready) routes.check_reply(m_data);
        end
    end

    initial begin
        #10ms;
        $display("prefix_route_table_tb NOT OK");
        $finish;
    end

    function automatic bit [31:0] prefix_mask(int len);
        return (len == 0) ? 32'h0 : ~32'h0 << (32 - len);
    endfunction

    function automatic prt_pkg::in_item_t noise_item();
        prt_pkg::in_item_t item;
        item.command = prt_pkg::cmd_t'($urandom_range(0, 3));
        item.route_mask = $urandom;
        item.route_net = $urandom;
        item.route_next_hop = $urandom;
        item.entry_index = 5'($urandom_range(0, 17));
        item.lookup_address = $urandom;
        return item;
    endfunction

    task automatic send_command(input prt_pkg::in_item_t item);
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic do_insert(input bit [31:0] mask, input bit [31:0] net,
                             input bit [31:0] hop);
        prt_pkg::in_item_t item;
        item = noise_item();
        item.command = prt_pkg::CMD_INSERT;
        item.route_mask = mask;
        item.route_net = net;
        item.route_next_hop = hop;
        send_command(item);
    endtask

    task automatic do_remove(input bit [4:0] idx);
        prt_pkg::in_item_t item;
        item = noise_item();
        item.command = prt_pkg::CMD_REMOVE;
        item.entry_index = idx;
        send_command(item);
    endtask

    task automatic do_lookup(input bit [31:0] addr);
        prt_pkg::in_item_t item;
        item = noise_item();
        item.command = prt_pkg::CMD_LOOKUP;
        item.lookup_address = addr;
        send_command(item);
    endtask

    task automatic do_reserved();
        prt_pkg::in_item_t item;
        item = noise_item();
        item.command = prt_pkg::CMD_RSVD;
        send_command(item);
    endtask

    task automatic put_reg(input prt_pkg::reg_idx_t idx, input bit [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_interfaces(input bit [31:0] a0, input bit [31:0] m0,
                                  input bit [31:0] a1, input bit [31:0] m1);
        put_reg(prt_pkg::REG_IFACE0_ADDR, a0);
        put_reg(prt_pkg::REG_IFACE0_MASK, m0);
        put_reg(prt_pkg::REG_IFACE1_ADDR, a1);
        put_reg(prt_pkg::REG_IFACE1_MASK, m1);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (routes.expected_replies.size() != 0);
    endtask

    task automatic random_commands(input int count, input int insert_pct);
        int r;
        int k;
        bit [31:0] mask;
        bit [31:0] addr;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < insert_pct) begin
                k = $urandom_range(0, 99);
                if (k < 70)
                    mask = prefix_mask(($urandom_range(0, 9) == 0) ? $urandom_range(0, 32)
                                                                   : $urandom_range(8, 32));
                else if (k < 85 || routes.route_count == 0)
                    mask = $urandom;
                else
                    mask = routes.masks[$urandom_range(0, routes.route_count - 1)];
                do_insert(mask, ($urandom_range(0, 99) < 85) ? ($urandom & mask) : $urandom,
                          $urandom);
            end else if (r < insert_pct + 25) begin
                if (routes.route_count > 0 && $urandom_range(0, 99) < 60)
                    do_remove(5'($urandom_range(2, routes.route_count + 1)));
                else
                    do_remove(5'($urandom_range(0, 17)));
            end else if (r < 97) begin
                k = $urandom_range(0, 99);
                if (k < 45 && routes.route_count > 0) begin
                    k = $urandom_range(0, routes.route_count - 1);
                    addr = (routes.nets[k] & routes.masks[k]) | ($urandom & ~routes.masks[k]);
                end else if (k < 55) begin
                    addr = (routes.if0_addr & routes.if0_mask) | ($urandom & ~routes.if0_mask);
                end else if (k < 65) begin
                    addr = (routes.if1_addr & routes.if1_mask) | ($urandom & ~routes.if1_mask);
                end else begin
                    addr = $urandom;
                end
                do_lookup(addr);
            end else begin
                do_reserved();
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_interfaces(32'h0A00_0001, 32'hFFFF_FF00, 32'hC0A8_0101, 32'hFFFF_0000);
        do_lookup(32'hC0A8_FFFF);
        do_lookup(32'h0A00_00FE);
        do_lookup(32'h0808_0808);
        do_insert(32'hFFFF_0000, 32'h0808_0000, 32'h1111_1111);
        do_insert(32'hFFFF_0000, 32'h0809_0000, 32'h2222_2222);
        do_insert(32'hFFFF_FFFF, 32'h0808_0808, 32'hFFFF_FFFF);
        do_insert(32'h0000_0000, 32'h0000_0000, 32'h3333_3333);
        do_lookup(32'h0808_0808);
        do_lookup(32'h0808_0001);
        do_lookup(32'h0809_0123);
        do_lookup(32'hFFFF_FFFF);
        do_lookup(32'h0000_0000);
        do_remove(5'd0);
        do_remove(5'd1);
        do_remove(5'd17);
        do_remove(5'd6);
        do_remove(5'd2);
        do_lookup(32'h0808_0808);
        do_reserved();
        do_remove(5'd4);
        do_lookup(32'h7F00_0001);
        do_insert(32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
        do_lookup(32'hFFFF_FFFF);

        // The receiver holds off for a while early in this phase.
        pressure_on = 1;
        random_commands(200, 35);
        drain();

        send_idle_pct = 66;
        set_interfaces($urandom, prefix_mask($urandom_range(1, 31)),
                       $urandom, prefix_mask($urandom_range(1, 31)));
        random_commands(200, 40);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 66;
        set_interfaces(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        random_commands(200, 25);
        drain();

        send_idle_pct = 33;
        recv_stall_pct = 33;
        set_interfaces($urandom, 32'h0000_0000, $urandom, prefix_mask($urandom_range(16, 32)));
        random_commands(100, 30);
        drain();

        set_interfaces(32'h0000_0000, prefix_mask($urandom_range(8, 24)),
                       32'hFFFF_FFFF, prefix_mask($urandom_range(8, 24)));
        random_commands(200, 30);
        drain();

        repeat (8) @(posedge aclk);
        if (routes.failed) begin
            $display("prefix_route_table_tb NOT OK");
        end else begin
            $display("prefix_route_table_tb OK");
        end
        $finish;
    end
endmodule
